### rtl/core/ear_input_highpass_schmitt_buffer_defines.svh
// -----------------------------------------------------------------------------
// EAR input buffer assertion macros
// Shared assertion forms, clocked on clock and disabled while reset is high.
// -----------------------------------------------------------------------------
`ifndef EAR_INPUT_HIGHPASS_SCHMITT_BUFFER_DEFINES_SVH
`define EAR_INPUT_HIGHPASS_SCHMITT_BUFFER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define EIHSB_ASSERT_IMPL(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define EIHSB_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/core/eihsb_pkg.sv
// -----------------------------------------------------------------------------
// EAR input buffer package
// Widths, filter coefficients, frame offset reciprocal and shared types.
// -----------------------------------------------------------------------------
package eihsb_pkg;

   // Buffer geometry: two halves of BUF_SAMPLES bits each.
   localparam int unsigned BUF_SAMPLES = 640;
   localparam int unsigned IDX_W       = $clog2(BUF_SAMPLES);
   localparam int unsigned BUF_DEPTH   = 2 * BUF_SAMPLES;
   localparam int unsigned ADDR_W      = $clog2(BUF_DEPTH);

   // Field widths.
   localparam int unsigned KIND_W   = 2;
   localparam int unsigned SAMPLE_W = 16;
   localparam int unsigned TSTAMP_W = 32;
   localparam int unsigned LEN_W    = 24;
   localparam int unsigned SIDX_W   = 10;

   localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(65000);

   // Filter arithmetic in Q15.
   localparam int unsigned Y_W    = 18;
   localparam int unsigned ACC_W  = 34;
   localparam int unsigned FRAC_W = 15;
   localparam logic signed [15:0]      COEF_B0    = 16'sd24331;
   localparam logic signed [15:0]      COEF_A1    = 16'sd15894;
   localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(16384);
   localparam logic signed [Y_W-1:0]   TRIG_ON    = Y_W'(1500);
   localparam logic signed [Y_W-1:0]   TRIG_OFF   = Y_W'(0);

   // Query division: numerator is delta * BUF_SAMPLES with delta below the
   // frame length, so the quotient always fits IDX_W bits.
   localparam int unsigned NUM_W     = LEN_W + IDX_W;
   localparam int unsigned DIV_CNT_W = $clog2(IDX_W + 1);

   // Frame offset (L + N) / (2N) as a multiply by a rounded-up reciprocal.
   // With K = sum width + ceil(log2(2N)) the truncated product is exact.
   localparam int unsigned FRAME_DIV     = 2 * BUF_SAMPLES;
   localparam int unsigned FRAME_SUM_W   = LEN_W + 1;
   localparam int unsigned FRAME_K       = FRAME_SUM_W + $clog2(FRAME_DIV);
   localparam int unsigned FRAME_RECIP_W = FRAME_K - $clog2(FRAME_DIV) + 1;
   localparam int unsigned FRAME_PROD_W  = FRAME_SUM_W + FRAME_RECIP_W;
   localparam logic [63:0] FRAME_RECIP_FULL =
      ((64'd1 << FRAME_K) + 64'(FRAME_DIV) - 64'd1) / 64'(FRAME_DIV);
   localparam logic [FRAME_RECIP_W-1:0] FRAME_RECIP = FRAME_RECIP_W'(FRAME_RECIP_FULL);

   // Item kinds.
   typedef enum logic [KIND_W-1:0] {
      KIND_SAMPLE = 2'd0,
      KIND_FRAME  = 2'd1,
      KIND_QUERY  = 2'd2
   } kind_type;

   // Divider status toward the sequencer.
   typedef struct packed {
      logic             done;
      logic [IDX_W-1:0] quotient;
   } div_stat_type;

endpackage

### rtl/core/eihsb_if.sv
// -----------------------------------------------------------------------------
// EAR input buffer channels
// Valid/ready channels for request items and response items.
// -----------------------------------------------------------------------------
interface eihsb_req_if;
   import eihsb_pkg::*;

   logic                       valid;
   logic                       ready;
   logic [KIND_W-1:0]          kind;
   logic signed [SAMPLE_W-1:0] sample;
   logic [TSTAMP_W-1:0]        tstamp;

   modport source (output valid, kind, sample, tstamp, input ready);
   modport sink   (input valid, kind, sample, tstamp, output ready);
endinterface

interface eihsb_rsp_if;
   import eihsb_pkg::*;

   logic              valid;
   logic              ready;
   logic              signal_high;
   logic [SIDX_W-1:0] sample_index;

   modport source (output valid, signal_high, sample_index, input ready);
   modport sink   (input valid, signal_high, sample_index, output ready);
endinterface

### rtl/core/eihsb_divider.sv
// -----------------------------------------------------------------------------
// EAR input buffer index divider
// Restoring division, one quotient bit per cycle, for the query index.
// -----------------------------------------------------------------------------
module eihsb_divider (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [eihsb_pkg::NUM_W-1:0]  numerator,
   input  logic [eihsb_pkg::LEN_W-1:0]  divisor,
   output eihsb_pkg::div_stat_type      status
);
   import eihsb_pkg::*;

   logic [LEN_W-1:0]     rem_ff;
   logic [IDX_W-1:0]     low_ff;
   logic [IDX_W-1:0]     quo_ff;
   logic [LEN_W-1:0]     dvs_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic                 done_ff;

   logic [LEN_W:0]   trial;
   logic [LEN_W:0]   diff;
   logic             fits;
   logic [LEN_W-1:0] rem_in;
   logic             busy;

   // The upper part of the numerator is below the divisor, so the partial
   // remainder never needs more than one extra bit.
   assign trial  = {rem_ff, low_ff[IDX_W-1]};
   assign diff   = trial - {1'b0, dvs_ff};
   assign fits   = trial >= {1'b0, dvs_ff};
   assign rem_in = fits ? diff[LEN_W-1:0] : trial[LEN_W-1:0];
   assign busy   = cnt_ff != '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= busy && (cnt_ff == DIV_CNT_W'(1));
         if (start) begin
            cnt_ff <= DIV_CNT_W'(IDX_W);
         end else if (busy) begin
            cnt_ff <= cnt_ff - DIV_CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= numerator[NUM_W-1 -: LEN_W];
         low_ff <= numerator[IDX_W-1:0];
         dvs_ff <= divisor;
      end else if (busy) begin
         rem_ff <= rem_in;
         low_ff <= low_ff << 1;
         quo_ff <= {quo_ff[IDX_W-2:0], fits};
      end
   end

   assign status.done     = done_ff;
   assign status.quotient = quo_ff;

endmodule

### rtl/core/ear_input_highpass_schmitt_buffer.sv
// -----------------------------------------------------------------------------
// EAR input high-pass filter, Schmitt trigger and double buffer
// Three kinds of request item share one channel. An audio sample goes through
// a Q15 first-order high-pass filter and a Schmitt trigger (high above 1500,
// held while above 0); the resulting bit is written into the fill half of a
// 2 x 640 bit buffer, and the halves swap when the fill half is full. A frame
// item records the frame start time less half a bin. A query maps its time
// stamp to a position in the readable half and returns that bit and the
// position, the only item that produces a response. Items are handled one at
// a time: a sample as filter products, then accumulate, trigger and buffer
// write; a frame item as reciprocal multiply, then subtract; and a query as
// the time difference, the product, the index divider steps, the step in
// which the divider reports done, a read of the bit memory and a load into
// the response register, with the divider skipped when the time is at or
// past the end of the frame and the index clamps to the last position. The
// response sits in an output register, so the next item is taken while a
// response waits; a second query only stalls at its final step until the
// first one is taken.
// The frame length register must be written while the block is idle. No
// clearing pass runs after reset: the half that fills first is always full
// before it becomes readable, and the other half reads as zero until it has
// been filled once.
// -----------------------------------------------------------------------------
`include "ear_input_highpass_schmitt_buffer_defines.svh"

module ear_input_highpass_schmitt_buffer (
   input  logic                        clock,
   input  logic                        reset,
   eihsb_req_if.sink                   req_ch,
   eihsb_rsp_if.source                 rsp_ch,
   input  logic                        csr_we,
   input  logic [eihsb_pkg::LEN_W-1:0] csr_wdata
);
   import eihsb_pkg::*;

   // Sequencer states, one-hot.
   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_FILT  = 7'b0000010,
      S_FRAME = 7'b0000100,
      S_QMUL  = 7'b0001000,
      S_QDIV  = 7'b0010000,
      S_QREAD = 7'b0100000,
      S_QLOAD = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   // Architectural state.
   logic [LEN_W-1:0]           frame_len_ff;
   logic signed [SAMPLE_W-1:0] prev_in_ff;
   logic signed [Y_W-1:0]      prev_out_ff;
   logic                       trig_ff;
   logic [IDX_W-1:0]           fill_ptr_ff;
   logic                       read_half_ff;
   logic                       half1_full_ff;
   logic [TSTAMP_W-1:0]        frame_start_ff;

   // Bit memory and its registered read port.
   logic bit_mem [BUF_DEPTH];
   logic mem_rd_ff;

   // Work registers for the item in flight.
   logic signed [ACC_W-1:0]  pb_ff;
   logic signed [ACC_W-1:0]  pa_ff;
   logic [TSTAMP_W-1:0]      tstamp_ff;
   logic [FRAME_PROD_W-1:0]  frame_prod_ff;
   logic [LEN_W-1:0]         delta_lo_ff;
   logic                     clamp_ff;
   logic [IDX_W-1:0]         idx_ff;

   // Response register.
   logic              rsp_valid_ff;
   logic              rsp_bit_ff;
   logic [SIDX_W-1:0] rsp_idx_ff;

   // Combinational terms.
   logic                       accept;
   logic signed [SAMPLE_W:0]   dx;
   logic signed [ACC_W-1:0]    pb_in;
   logic signed [ACC_W-1:0]    pa_in;
   logic signed [ACC_W-1:0]    acc;
   logic signed [Y_W-1:0]      y_val;
   logic                       trig_in;
   logic                       fill_half;
   logic                       last_pos;
   logic [ADDR_W-1:0]          wr_addr;
   logic [ADDR_W-1:0]          rd_addr;
   logic [TSTAMP_W-1:0]        delta;
   logic                       clamp_in;
   logic [FRAME_SUM_W-1:0]     frame_sum;
   logic [FRAME_PROD_W-1:0]    frame_prod_in;
   logic [FRAME_PROD_W-1:0]    frame_off;
   logic [NUM_W-1:0]           div_num;
   logic                       div_start;
   div_stat_type               div_stat;
   logic                       out_bit;
   logic                       rsp_free;

   assign accept       = req_ch.valid && req_ch.ready;
   assign req_ch.ready = (state_ff == S_IDLE);

   // Filter, first cycle: difference and both products straight from the
   // request and the stored history.
   assign dx    = $signed({req_ch.sample[SAMPLE_W-1], req_ch.sample})
                - $signed({prev_in_ff[SAMPLE_W-1], prev_in_ff});
   assign pb_in = dx * COEF_B0;
   assign pa_in = prev_out_ff * COEF_A1;

   // Filter, second cycle: rounded sum, arithmetic shift by 15 (a floor),
   // then the trigger with hysteresis.
   assign acc     = pb_ff + pa_ff + ROUND_HALF;
   assign y_val   = acc[FRAC_W +: Y_W];
   assign trig_in = trig_ff ? (y_val > TRIG_OFF) : (y_val > TRIG_ON);

   // The fill half is always the one that is not readable.
   assign fill_half = ~read_half_ff;
   assign last_pos  = (fill_ptr_ff == IDX_W'(BUF_SAMPLES - 1));
   assign wr_addr   = fill_half ? ADDR_W'(BUF_SAMPLES) + ADDR_W'(fill_ptr_ff)
                                : ADDR_W'(fill_ptr_ff);

   // Frame offset: (L + N) / (2N) through the reciprocal, product registered.
   assign frame_sum     = FRAME_SUM_W'(frame_len_ff) + FRAME_SUM_W'(BUF_SAMPLES);
   assign frame_prod_in = FRAME_PROD_W'(frame_sum) * FRAME_PROD_W'(FRAME_RECIP);
   assign frame_off     = frame_prod_ff >> FRAME_K;

   // Query: a time at or past the frame length (and any time when the length
   // is zero) clamps to the last position; otherwise delta fits the length
   // width and the quotient of delta * N by the length is below N.
   assign delta     = req_ch.tstamp - frame_start_ff;
   assign clamp_in  = delta >= TSTAMP_W'(frame_len_ff);
   assign div_num   = NUM_W'(delta_lo_ff) * NUM_W'(BUF_SAMPLES);
   assign div_start = (state_ff == S_QMUL) && !clamp_ff;

   assign rd_addr = read_half_ff ? ADDR_W'(BUF_SAMPLES) + ADDR_W'(idx_ff)
                                 : ADDR_W'(idx_ff);

   // Half 1 has never been written until a swap first makes it readable.
   assign out_bit  = mem_rd_ff & ~(read_half_ff & ~half1_full_ff);
   assign rsp_free = !rsp_valid_ff || rsp_ch.ready;

   eihsb_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .numerator (div_num),
      .divisor   (frame_len_ff),
      .status    (div_stat)
   );

   // Sequencer. Only one item is in flight, so a buffer write and a later
   // read of the same entry can never overlap.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_ch.kind)
                  KIND_SAMPLE: state_in = S_FILT;
                  KIND_FRAME:  state_in = S_FRAME;
                  KIND_QUERY:  state_in = S_QMUL;
                  default:     state_in = S_IDLE;
               endcase
            end
         end
         S_FILT:  state_in = S_IDLE;
         S_FRAME: state_in = S_IDLE;
         S_QMUL:  state_in = clamp_ff ? S_QREAD : S_QDIV;
         S_QDIV: begin
            if (div_stat.done) begin
               state_in = S_QREAD;
            end
         end
         S_QREAD: state_in = S_QLOAD;
         S_QLOAD: begin
            if (rsp_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Control and architectural state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         frame_len_ff   <= LEN_RESET;
         prev_in_ff     <= '0;
         prev_out_ff    <= '0;
         trig_ff        <= 1'b0;
         fill_ptr_ff    <= '0;
         read_half_ff   <= 1'b1;
         half1_full_ff  <= 1'b0;
         frame_start_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            frame_len_ff <= csr_wdata;
         end
         if (accept && (req_ch.kind == KIND_SAMPLE)) begin
            prev_in_ff <= req_ch.sample;
         end
         if (state_ff == S_FILT) begin
            prev_out_ff <= y_val;
            trig_ff     <= trig_in;
            if (last_pos) begin
               fill_ptr_ff  <= '0;
               read_half_ff <= fill_half;
               if (fill_half) begin
                  half1_full_ff <= 1'b1;
               end
            end else begin
               fill_ptr_ff <= fill_ptr_ff + IDX_W'(1);
            end
         end
         if (state_ff == S_FRAME) begin
            frame_start_ff <= tstamp_ff - TSTAMP_W'(frame_off);
         end
         if ((state_ff == S_QLOAD) && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Work and response payload registers.
   always_ff @(posedge clock) begin
      if (accept) begin
         pb_ff         <= pb_in;
         pa_ff         <= pa_in;
         tstamp_ff     <= req_ch.tstamp;
         frame_prod_ff <= frame_prod_in;
         delta_lo_ff   <= delta[LEN_W-1:0];
         clamp_ff      <= clamp_in;
      end
      if ((state_ff == S_QMUL) && clamp_ff) begin
         idx_ff <= IDX_W'(BUF_SAMPLES - 1);
      end else if ((state_ff == S_QDIV) && div_stat.done) begin
         idx_ff <= div_stat.quotient;
      end
      if ((state_ff == S_QLOAD) && rsp_free) begin
         rsp_bit_ff <= out_bit;
         rsp_idx_ff <= SIDX_W'(idx_ff);
      end
   end

   // Bit memory: one write port for samples, one registered read for queries.
   always_ff @(posedge clock) begin
      if (state_ff == S_FILT) begin
         bit_mem[wr_addr] <= trig_in;
      end
      if (state_ff == S_QREAD) begin
         mem_rd_ff <= bit_mem[rd_addr];
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.signal_high  = rsp_bit_ff;
   assign rsp_ch.sample_index = rsp_idx_ff;

   `EIHSB_ASSERT_IMPL(a_div_done_in_wait, div_stat.done, state_ff == S_QDIV, "divider done outside wait state")
   `EIHSB_ASSERT_IMPL(a_fill_ptr_range, 1'b1, {1'b0, fill_ptr_ff} < (IDX_W + 1)'(BUF_SAMPLES), "fill pointer out of range")
   `EIHSB_ASSERT_IMPL(a_read_idx_range, state_ff == S_QREAD, {1'b0, idx_ff} < (IDX_W + 1)'(BUF_SAMPLES), "query index out of range")
   `EIHSB_ASSERT_NEXT(a_swap_on_full, (state_ff == S_FILT) && last_pos, read_half_ff != $past(read_half_ff), "halves did not swap on a full fill half")
   `EIHSB_ASSERT_IMPL(a_rsp_from_load, $rose(rsp_valid_ff), $past(state_ff) == S_QLOAD, "response raised outside the load step")

endmodule
